@@ rtl/core/stepper_full_step_pwm_driver_core_macros.svh @@
// Assertion macros for the stepper driver checker.
// Used by files that assert; no other dependencies.
`ifndef STEPPER_FULL_STEP_PWM_DRIVER_CORE_MACROS_SVH
`define STEPPER_FULL_STEP_PWM_DRIVER_CORE_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while in reset.
`define SFSPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SFSPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sfspd_pkg.sv @@
// Shared types, register map and step table for the stepper driver.
// No dependencies.
package sfspd_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegStepPeriod      = 3'd0;
  localparam logic [2:0] RegMsDivider       = 3'd1;
  localparam logic [2:0] RegKeepalivePeriod = 3'd2;
  localparam logic [2:0] RegKeepalivePulse  = 3'd3;
  localparam logic [2:0] RegBoostTicks      = 3'd4;
  localparam logic [2:0] RegHoldDuty        = 3'd5;

  localparam logic [16:0] StepPeriodRst      = 17'd89932;
  localparam logic [7:0]  MsDividerRst       = 8'd10;
  localparam logic [15:0] KeepalivePeriodRst = 16'd9000;
  localparam logic [15:0] KeepalivePulseRst  = 16'd700;
  localparam logic [7:0]  BoostTicksRst      = 8'd80;
  localparam logic [2:0]  HoldDutyRst        = 3'd3;

  localparam logic [2:0] FullDuty = 3'd4;

  typedef struct packed {
    logic [16:0] step_period;
    logic [7:0]  ms_divider;
    logic [15:0] keepalive_period;
    logic [15:0] keepalive_pulse;
    logic [7:0]  boost_ticks;
    logic [2:0]  hold_duty;
  } sfspd_cfg_t;

  typedef struct packed {
    logic [16:0] tick_count;
    logic [7:0]  ms_prescale;
    logic [15:0] keepalive_clock;
    logic        keepalive_level;
    logic [1:0]  pwm_phase;
    logic [1:0]  step_position;
    logic [3:0]  coil_pattern;
    logic [7:0]  boost_left;
    logic [2:0]  duty;
    logic [3:0]  coil_latch;
  } sfspd_state_t;

  typedef struct packed {
    logic [1:0] position;
    logic       keepalive;
    logic [3:0] coil_drive;
  } sfspd_result_t;

  // Full-step coil pattern by position: bit0 A1, bit1 B1, bit2 A2, bit3 B2
  function automatic logic [3:0] full_step_pattern(input logic [1:0] pos);
    logic [3:0] pat;
    case (pos)
      2'd0:    pat = 4'h9;
      2'd1:    pat = 4'h3;
      2'd2:    pat = 4'h6;
      default: pat = 4'hC;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/sfspd_tick.sv @@
// Next-state and result logic for one tick of the stepper driver.
// Depends on sfspd_pkg.
module sfspd_tick import sfspd_pkg::*; (
  input  logic          enable_i,
  input  sfspd_cfg_t    cfg_i,
  input  sfspd_state_t  state_i,
  output sfspd_state_t  state_o,
  output sfspd_result_t result_o
);

  logic [17:0] tick_inc;
  logic        stepped;
  logic [1:0]  pos_new;
  logic [8:0]  pre_inc;
  logic        ms_hit;
  logic [16:0] clk_inc;
  logic [15:0] clk_new;
  logic [2:0]  phase_inc;
  logic        phase_wrap;
  logic [1:0]  phase_new;
  logic [3:0]  latch_tmp;
  logic [3:0]  latch_out;
  logic [7:0]  boost_dec;

  always_comb begin
    state_o = state_i;

    tick_inc = {1'b0, state_i.tick_count} + 18'd1;
    stepped  = tick_inc >= {1'b0, cfg_i.step_period};
    pos_new  = stepped ? state_i.step_position - 2'd1 : state_i.step_position;

    pre_inc = {1'b0, state_i.ms_prescale} + 9'd1;
    ms_hit  = pre_inc >= {1'b0, cfg_i.ms_divider};
    clk_inc = {1'b0, state_i.keepalive_clock} + 17'd1;
    clk_new = (clk_inc > {1'b0, cfg_i.keepalive_period}) ? '0 : clk_inc[15:0];

    // phase restarts on a step before advancing
    phase_inc  = stepped ? 3'd1 : {1'b0, state_i.pwm_phase} + 3'd1;
    phase_wrap = phase_inc[2];
    phase_new  = phase_wrap ? 2'd0 : phase_inc[1:0];
    latch_tmp  = phase_wrap ? state_i.coil_pattern : state_i.coil_latch;
    latch_out  = ({1'b0, phase_new} >= state_i.duty) ? 4'h0 : latch_tmp;

    boost_dec = state_i.boost_left - 8'd1;

    if (enable_i) begin
      state_o.tick_count    = stepped ? '0 : tick_inc[16:0];
      state_o.step_position = pos_new;
      state_o.ms_prescale   = ms_hit ? '0 : pre_inc[7:0];
      if (ms_hit) begin
        state_o.keepalive_clock = clk_new;
        state_o.keepalive_level = clk_new < cfg_i.keepalive_pulse;
      end
      state_o.pwm_phase  = phase_new;
      state_o.coil_latch = latch_out;

      if (stepped) begin
        state_o.coil_pattern = full_step_pattern(pos_new);
        state_o.coil_latch   = full_step_pattern(pos_new);
        state_o.boost_left   = cfg_i.boost_ticks;
        state_o.duty         = (cfg_i.boost_ticks == 8'd0) ? cfg_i.hold_duty : FullDuty;
      end else if (state_i.boost_left != 8'd0) begin
        state_o.boost_left = boost_dec;
        if (boost_dec == 8'd0) begin
          state_o.duty = cfg_i.hold_duty;
        end
      end

      result_o.coil_drive = latch_out;
      result_o.keepalive  = state_o.keepalive_level;
      result_o.position   = pos_new;
    end else begin
      result_o.coil_drive = state_i.coil_latch;
      result_o.keepalive  = state_i.keepalive_level;
      result_o.position   = state_i.step_position;
    end
  end

endmodule

@@ rtl/core/stepper_full_step_pwm_driver_core.sv @@
// Stepper driver core: full-step two-phase coil drive with boost/hold PWM
// and a keep-alive pin, one tick per input request.
//
// Input stream: each request carries enable in tdata[0]; enable high
// advances the driver by one tick, enable low leaves all state alone and
// repeats the present outputs. Every request gives exactly one result.
// Output stream: tdata[3:0] coil drive, [4] keep-alive level, [6:5] step
// position. Configuration over the APB port; the user must write it only while
// idle, as the block itself does not enforce it. A request is held in the input
// register, then its result in the result register. Throughput: one request
// per cycle while the receiver takes results, bound by the combinational tick logic.
// When the receiver stalls, one further request is taken into the input
// register and then s_axis_tready drops until the result is taken.
// Reset: all counters, coils off, position 0, registers to their defaults.
module stepper_full_step_pwm_driver_core import sfspd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] enable, [7:1] zero
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [3:0] coil_drive, [4] keepalive, [6:5] position
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  sfspd_cfg_t    cfg_q;
  sfspd_state_t  state_q, state_d;
  sfspd_result_t result_d, result_q;
  logic          in_valid_q;
  logic          in_enable_q;
  logic          out_valid_q;
  logic          advance;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period      <= StepPeriodRst;
      cfg_q.ms_divider       <= MsDividerRst;
      cfg_q.keepalive_period <= KeepalivePeriodRst;
      cfg_q.keepalive_pulse  <= KeepalivePulseRst;
      cfg_q.boost_ticks      <= BoostTicksRst;
      cfg_q.hold_duty        <= HoldDutyRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegStepPeriod:      cfg_q.step_period      <= pwdata[16:0];
        RegMsDivider:       cfg_q.ms_divider       <= pwdata[7:0];
        RegKeepalivePeriod: cfg_q.keepalive_period <= pwdata[15:0];
        RegKeepalivePulse:  cfg_q.keepalive_pulse  <= pwdata[15:0];
        RegBoostTicks:      cfg_q.boost_ticks      <= pwdata[7:0];
        RegHoldDuty:        cfg_q.hold_duty        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegStepPeriod:      prdata = {15'd0, cfg_q.step_period};
      RegMsDivider:       prdata = {24'd0, cfg_q.ms_divider};
      RegKeepalivePeriod: prdata = {16'd0, cfg_q.keepalive_period};
      RegKeepalivePulse:  prdata = {16'd0, cfg_q.keepalive_pulse};
      RegBoostTicks:      prdata = {24'd0, cfg_q.boost_ticks};
      RegHoldDuty:        prdata = {29'd0, cfg_q.hold_duty};
      default:            prdata = '0;
    endcase
  end

  // input register moves on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  sfspd_tick u_tick (
    .enable_i (in_enable_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_enable_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q  <= 1'b1;
        in_enable_q <= s_axis_tdata[0];
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

endmodule

@@ rtl/core/sfspd_checker.sv @@
// Port-level checks for the stepper driver core, bound to the top level.
// Depends on sfspd_pkg and the assertion macro header.
`include "stepper_full_step_pwm_driver_core_macros.svh"

module sfspd_checker import sfspd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       psel,
  input logic       penable
);

  logic [3:0] coil;
  logic [1:0] pos;
  logic [1:0] pos_old;
  logic       coil_ok;
  logic       stall;

  assign coil    = m_axis_tdata[3:0];
  assign pos     = m_axis_tdata[6:5];
  // position moves backwards, so the one just left is one above
  assign pos_old = pos + 2'd1;
  assign coil_ok = (coil == 4'h0) || (coil == full_step_pattern(pos)) ||
                   (coil == full_step_pattern(pos_old));
  assign stall   = m_axis_tvalid && !m_axis_tready;

  // a stalled result holds
  `SFSPD_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // energised coils match the reported position, or on a step tick the one left
  `SFSPD_ASSERT(a_coil_pos, clk_i, rst_ni, !m_axis_tvalid || coil_ok, "coil pattern does not match position")

  // with the result waiting and the input register full, no request is taken
  `SFSPD_ASSERT_NEXT(a_backpressure, clk_i, rst_ni, stall && s_axis_tvalid && s_axis_tready && !(psel && penable), !m_axis_tready && m_axis_tvalid |-> !s_axis_tready, "request taken with both stages full")

  // padding bit stays clear
  `SFSPD_ASSERT(a_pad, clk_i, rst_ni, !m_axis_tvalid || !m_axis_tdata[7], "tdata padding bit set")

endmodule

bind stepper_full_step_pwm_driver_core sfspd_checker u_sfspd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable)
);

@@ dv/tb_stepper_full_step_pwm_driver_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the stepper driver core: streams tick requests,
// predicts coil drive, keep-alive and position and checks every result.
// Depends on sfspd_pkg and stepper_full_step_pwm_driver_core.
module tb_stepper_full_step_pwm_driver_core;
  import sfspd_pkg::*;

  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned RandPhases   = 12;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned RxHoldCycles = 400;
  // coil pattern per position, position 0 in the low nibble
  localparam logic [15:0] CoilTable    = 16'hC639;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [0] enable, [7:1] zero
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;         // [3:0] coil_drive, [4] keepalive, [6:5] position
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;

  stepper_full_step_pwm_driver_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // driver model state
  sfspd_cfg_t  drv_cfg;
  logic [16:0] tick_cnt;
  logic [7:0]  ms_cnt;
  logic [15:0] ka_clock;
  logic        ka_level;
  logic [1:0]  pwm_phase;
  logic [1:0]  step_pos;
  logic [3:0]  coil_pat;
  logic [7:0]  boost_left;
  logic [2:0]  duty;
  logic [3:0]  coil_latch;

  logic          pending_ticks[$];
  sfspd_result_t drive_expected[$];

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_gap      = 0;
  int unsigned rx_gap      = 0;
  int unsigned rx_hold     = 0;
  int unsigned rx_hold_req = 0;
  bit          offer_taken = 1'b0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // One tick of the driver; enable low only repeats the present outputs.
  task automatic advance_tick(input logic en, output sfspd_result_t res);
    int unsigned t;
    int unsigned c;
    int unsigned p;
    bit          stepped;
    stepped = 1'b0;
    if (en) begin
      t = tick_cnt + 1;
      if (t >= drv_cfg.step_period) begin
        t         = 0;
        pwm_phase = 2'd0;
        step_pos  = step_pos - 2'd1;
        stepped   = 1'b1;
      end
      tick_cnt = t[16:0];

      t = ms_cnt + 1;
      if (t >= drv_cfg.ms_divider) begin
        c = ka_clock + 1;
        t = 0;
        if (c > drv_cfg.keepalive_period) c = 0;
        ka_clock = c[15:0];
        ka_level = (ka_clock < drv_cfg.keepalive_pulse);
      end
      ms_cnt = t[7:0];

      p = pwm_phase + 1;
      if (p >= 4) begin
        p          = 0;
        coil_latch = coil_pat;
      end
      pwm_phase = p[1:0];
      if (p >= duty) coil_latch = 4'h0;
    end

    res.coil_drive = coil_latch;
    res.keepalive  = ka_level;
    res.position   = step_pos;

    if (stepped) begin
      coil_pat   = CoilTable[step_pos*4 +: 4];
      coil_latch = coil_pat;
      boost_left = drv_cfg.boost_ticks;
      duty       = (boost_left == 8'd0) ? drv_cfg.hold_duty : FullDuty;
    end else if (en && boost_left != 8'd0) begin
      boost_left = boost_left - 8'd1;
      if (boost_left == 8'd0) duty = drv_cfg.hold_duty;
    end
  endtask

  // Result check first, then the accepted request, so the queue order is fixed.
  always @(posedge clk_i) begin
    sfspd_result_t want;
    sfspd_result_t res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tdata %h", m_axis_tdata);
      end else begin
        want = drive_expected.pop_front();
        if (m_axis_tdata[3:0] !== want.coil_drive || m_axis_tdata[4] !== want.keepalive ||
            m_axis_tdata[6:5] !== want.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected coil %h ka %b pos %0d, got coil %h ka %b pos %0d",
                     want.coil_drive, want.keepalive, want.position,
                     m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[6:5]);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_tick(s_axis_tdata[0], res);
      drive_expected.push_back(res);
      offer_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    logic valid_next;
    if (rst_ni) begin
      valid_next  = s_axis_tvalid && !offer_taken;
      offer_taken = 1'b0;
      if (!valid_next) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_ticks.size() != 0) begin
          s_axis_tdata <= {7'b0, pending_ticks.pop_front()};
          valid_next   = 1'b1;
          tx_gap       = sender_calm ? 0 : pick_gap();
        end
      end
      s_axis_tvalid <= valid_next;
    end
  end

  // result receiver; a long hold-off is counted here once requested
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req != 0) begin
        rx_hold     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!receiver_calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  task automatic settle();
    @(negedge clk_i);
    #1;
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegStepPeriod:      drv_cfg.step_period      = value[16:0];
      RegMsDivider:       drv_cfg.ms_divider       = value[7:0];
      RegKeepalivePeriod: drv_cfg.keepalive_period = value[15:0];
      RegKeepalivePulse:  drv_cfg.keepalive_pulse  = value[15:0];
      RegBoostTicks:      drv_cfg.boost_ticks      = value[7:0];
      RegHoldDuty:        drv_cfg.hold_duty        = value[2:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input int unsigned step, input int unsigned msdiv,
                                input int unsigned kper, input int unsigned kpulse,
                                input int unsigned boost, input int unsigned hold);
    apb_write(RegStepPeriod, step);
    apb_write(RegMsDivider, msdiv);
    apb_write(RegKeepalivePeriod, kper);
    apb_write(RegKeepalivePulse, kpulse);
    apb_write(RegBoostTicks, boost);
    apb_write(RegHoldDuty, hold);
    #1;
  endtask

  // wait until every request is taken and every result has come back
  task automatic drain();
    while (pending_ticks.size() != 0 || s_axis_tvalid || drive_expected.size() != 0)
      settle();
    repeat (4) settle();
  endtask

  task automatic push_pattern(input logic [31:0] bits, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) pending_ticks.push_back(bits[i]);
  endtask

  initial begin
    int unsigned kper;
    drv_cfg.step_period      = StepPeriodRst;
    drv_cfg.ms_divider       = MsDividerRst;
    drv_cfg.keepalive_period = KeepalivePeriodRst;
    drv_cfg.keepalive_pulse  = KeepalivePulseRst;
    drv_cfg.boost_ticks      = BoostTicksRst;
    drv_cfg.hold_duty        = HoldDutyRst;
    tick_cnt   = '0;
    ms_cnt     = '0;
    ka_clock   = '0;
    ka_level   = 1'b0;
    pwm_phase  = '0;
    step_pos   = '0;
    coil_pat   = '0;
    boost_left = '0;
    duty       = '0;
    coil_latch = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    #1;

    // defaults after reset: coils off before the first step
    push_pattern(32'b1101_1011, 8);
    drain();
    // step every tick, ms every tick, hold duty above four, no boost
    write_settings(0, 0, 1, 1, 0, 7);
    push_pattern(32'b1_0111_0111, 9);
    drain();
    // step during boost restarts it; zero hold duty gates the coils off
    write_settings(2, 1, 3, 2, 3, 0);
    push_pattern(32'b1110_1111, 8);
    drain();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      sender_calm   = (ph == 2) || ($urandom_range(0, 3) == 0);
      receiver_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        write_settings(131071, 255, 65535, 65535, 255, 4);
      end else if (ph == 1) begin
        write_settings(1, 1, 1, 0, 0, 0);
      end else begin
        kper = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
        write_settings(
          ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 12),
          ($urandom_range(0, 9) < 2) ? $urandom_range(0, 255) : $urandom_range(0, 5),
          kper,
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, kper + 2),
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8),
          $urandom_range(0, 7));
      end
      for (int unsigned i = 0; i < PhaseItems; i++)
        pending_ticks.push_back($urandom_range(0, 99) < 85);
      // receiver holds off while the sender keeps offering
      if (ph == 3) rx_hold_req = RxHoldCycles;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
